FILE: rtl/cahp_pkg.sv
// Shared types and constants for the archive header parser.
`default_nettype none

package cahp_pkg;

   localparam int PosWidth = 4;

   localparam logic [3:0] ERR_NONE        = 4'd0;
   localparam logic [3:0] ERR_VERSION     = 4'd1;
   localparam logic [3:0] ERR_SIGNATURE   = 4'd2;
   localparam logic [3:0] ERR_RECORD_FLAG = 4'd3;
   localparam logic [3:0] ERR_ZERO_LEN    = 4'd4;
   localparam logic [3:0] ERR_AMBIG_LEN   = 4'd5;
   localparam logic [3:0] ERR_FLAGS       = 4'd6;
   localparam logic [3:0] ERR_RATIO       = 4'd7;
   localparam logic [3:0] ERR_BLOCK_SIZE  = 4'd8;
   localparam logic [3:0] ERR_TRUNCATED   = 4'd9;

   localparam logic [7:0] VER_NATIVE = 8'h01;
   localparam logic [7:0] VER_PACK2  = 8'h02;
   localparam logic [7:0] VER_SPACK  = 8'h05;
   localparam logic [7:0] VER_PACK7  = 8'h07;
   localparam logic [7:0] VER_PACK9  = 8'h09;

   localparam logic [7:0] SIG_BYTE0 = 8'h89;
   localparam logic [7:0] SIG_BYTE1 = 8'h69;
   localparam logic [7:0] SIG_BYTE2 = 8'hA5;

   localparam logic [PosWidth-1:0] POS_VERSION   = 4'd0;
   localparam logic [PosWidth-1:0] POS_RECFLAG   = 4'd1;
   localparam logic [PosWidth-1:0] POS_SLEN_HI   = 4'd2;
   localparam logic [PosWidth-1:0] POS_SLEN_LO   = 4'd3;
   localparam logic [PosWidth-1:0] POS_FLAGS     = 4'd4;
   localparam logic [PosWidth-1:0] POS_RATIO     = 4'd5;
   localparam logic [PosWidth-1:0] POS_BLK_HI    = 4'd6;
   localparam logic [PosWidth-1:0] POS_BLK_LO    = 4'd7;
   localparam logic [PosWidth-1:0] POS_NAT_LEN   = 4'd4;
   localparam logic [PosWidth-1:0] POS_NAT_LAST  = 4'd5;
   localparam logic [PosWidth-1:0] POS_PACK_LAST = 4'd11;

   localparam logic [7:0] FLAG_EXTENDED = 8'h04;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [3:0]  error_code;
      logic [7:0]  version_code;
      logic [31:0] record_length;
      logic        variable_records;
      logic        spack_mode;
      logic [7:0]  mode_flags;
      logic [7:0]  compression_ratio;
      logic [15:0] block_size;
   } rsp_type;

   typedef struct packed {
      logic    emit;
      rsp_type rsp;
   } step_type;

endpackage

`default_nettype wire

FILE: rtl/compressed_archive_header_parser_top.sv
// Top level of the archive header parser: input register, parser, result register.
//
//   channel | ports                          | direction | moves per transaction
//   --------+--------------------------------+-----------+----------------------------
//   request | req_valid, req_stall, req_item | in        | one header byte or end mark
//   result  | rsp_valid, rsp_stall, rsp_item | out       | one parse result
//
// A transaction is taken each cycle while req_stall is low; a result for the byte that
// completes a header or hits an error passes the input and then the result register.
// Reset is synchronous and returns the parser to await a version byte.
// A stalled result holds; bytes that give no result keep flowing, one that gives a
// result waits in the input register until the result register frees.
`default_nettype none

module compressed_archive_header_parser_top
   import cahp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_item,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_item
);

   logic     in_valid_ff, in_valid_in;
   req_type  in_item_ff;
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_item_ff;
   step_type step;
   logic     advance;
   logic     accept;

   cahp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_item_ff),
      .step    (step)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall || !step.emit);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance && step.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= req_item;
      end
      if (advance && step.emit) begin
         rsp_item_ff <= step.rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire

FILE: rtl/cahp_parser.sv
// Header parser state and per-byte step logic.
`default_nettype none

module cahp_parser
   import cahp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     step_en,
   input  wire req_type  item,
   output step_type      step
);

   logic [PosWidth-1:0] pos_ff, pos_in;
   logic [7:0]          version_ff, version_in;
   logic                sig_ff, sig_in;
   logic [15:0]         short_ff, short_in;
   logic                var_ff, var_in;
   logic [7:0]          flags_ff, flags_in;
   logic [7:0]          ratio_ff, ratio_in;
   logic [15:0]         blk_ff, blk_in;
   logic [31:0]         long_ff, long_in;

   logic [7:0]  b;
   logic [15:0] short_full;
   logic [31:0] long_full;

   assign b          = item.data_byte;
   assign short_full = {short_ff[15:8], b};
   assign long_full  = {long_ff[23:0], b};

   always_comb begin
      pos_in     = pos_ff;
      version_in = version_ff;
      sig_in     = sig_ff;
      short_in   = short_ff;
      var_in     = var_ff;
      flags_in   = flags_ff;
      ratio_in   = ratio_ff;
      blk_in     = blk_ff;
      long_in    = long_ff;
      step       = '0;
      step.rsp.version_code = version_ff;

      if (item.end_of_input) begin
         step.emit           = 1'b1;
         step.rsp.error_code = ERR_TRUNCATED;
      end else if (pos_ff == POS_VERSION) begin
         version_in = b;
         step.rsp.version_code = b;
         if (b inside {VER_NATIVE, VER_PACK2, VER_SPACK, VER_PACK7, VER_PACK9}) begin
            pos_in = POS_RECFLAG;
         end else begin
            step.emit           = 1'b1;
            step.rsp.error_code = ERR_VERSION;
         end
      end else if (version_ff == VER_NATIVE) begin
         pos_in = pos_ff + PosWidth'(1);
         case (pos_ff)
            4'd1: if (b != SIG_BYTE0) sig_in = 1'b0;
            4'd2: if (b != SIG_BYTE1) sig_in = 1'b0;
            4'd3: if (b != SIG_BYTE2) sig_in = 1'b0;
            POS_NAT_LEN: short_in = {b, 8'h00};
            default: begin
               step.emit = 1'b1;
               if (!sig_ff) begin
                  step.rsp.error_code = ERR_SIGNATURE;
               end else begin
                  step.rsp.record_length = {16'h0000, short_full};
               end
            end
         endcase
      end else begin
         pos_in = pos_ff + PosWidth'(1);
         case (pos_ff)
            POS_RECFLAG: begin
               if (b > 8'd1) begin
                  step.emit           = 1'b1;
                  step.rsp.error_code = ERR_RECORD_FLAG;
               end
               var_in = b[0];
            end
            POS_SLEN_HI: short_in = {b, 8'h00};
            POS_SLEN_LO: short_in = short_full;
            POS_FLAGS:   flags_in = b;
            POS_RATIO:   ratio_in = b;
            POS_BLK_HI:  blk_in   = {b, 8'h00};
            POS_BLK_LO:  blk_in   = {blk_ff[15:8], b};
            default: begin
               long_in = long_full;
               if (pos_ff >= POS_PACK_LAST) begin
                  step.emit = 1'b1;
                  if (short_ff == 16'h0000 && long_full == 32'h0) begin
                     step.rsp.error_code = ERR_ZERO_LEN;
                  end else if (short_ff != 16'h0000 && long_full != 32'h0 &&
                               {16'h0000, short_ff} != long_full) begin
                     step.rsp.error_code = ERR_AMBIG_LEN;
                  end else if ((flags_ff & FLAG_EXTENDED) == 8'h00 && flags_ff != 8'h00) begin
                     step.rsp.error_code = ERR_FLAGS;
                  end else if ((flags_ff & FLAG_EXTENDED) == 8'h00 && ratio_ff != 8'h00) begin
                     step.rsp.error_code = ERR_RATIO;
                  end else if ((flags_ff & FLAG_EXTENDED) == 8'h00 && blk_ff != 16'h0000) begin
                     step.rsp.error_code = ERR_BLOCK_SIZE;
                  end else begin
                     step.rsp.record_length     = (short_ff != 16'h0000) ?
                                                  {16'h0000, short_ff} : long_full;
                     step.rsp.variable_records  = var_ff;
                     step.rsp.spack_mode        = (version_ff == VER_SPACK);
                     step.rsp.mode_flags        = flags_ff;
                     step.rsp.compression_ratio = ratio_ff;
                     step.rsp.block_size        = blk_ff;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step_en && step.emit)) begin
         pos_ff     <= POS_VERSION;
         version_ff <= 8'h00;
         sig_ff     <= 1'b1;
         short_ff   <= 16'h0000;
         var_ff     <= 1'b0;
         flags_ff   <= 8'h00;
         ratio_ff   <= 8'h00;
         blk_ff     <= 16'h0000;
         long_ff    <= 32'h0;
      end else if (step_en) begin
         pos_ff     <= pos_in;
         version_ff <= version_in;
         sig_ff     <= sig_in;
         short_ff   <= short_in;
         var_ff     <= var_in;
         flags_ff   <= flags_in;
         ratio_ff   <= ratio_in;
         blk_ff     <= blk_in;
         long_ff    <= long_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/cahp_checker.sv
// Port-level checks for the archive header parser, bound to the top level.
`default_nettype none

module cahp_checker
   import cahp_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_item
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("result valid or input stalled right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("stalled result changed");

   a_err_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.error_code <= ERR_TRUNCATED)
      else $error("error code out of range");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.error_code != ERR_NONE |->
         rsp_item.record_length == 32'h0 && rsp_item.variable_records == 1'b0 &&
         rsp_item.spack_mode == 1'b0 && rsp_item.mode_flags == 8'h00 &&
         rsp_item.compression_ratio == 8'h00 && rsp_item.block_size == 16'h0000)
      else $error("error result carries nonzero fields");

   a_ok_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.error_code == ERR_NONE |->
         (rsp_item.record_length != 32'h0 || rsp_item.version_code == VER_NATIVE) &&
         rsp_item.spack_mode == (rsp_item.version_code == VER_SPACK))
      else $error("good result with zero length or wrong spack mode");

endmodule

bind compressed_archive_header_parser_top cahp_checker u_cahp_checker (.*);

`default_nettype wire
